// ===== rtl/core/unix_calendar_converter_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef UNIX_CALENDAR_CONVERTER_DEFINES_SVH
`define UNIX_CALENDAR_CONVERTER_DEFINES_SVH

// Require cons in the same cycle as ante.
`define UCC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ucc: same-cycle check failed");

// Require cons in the cycle after ante.
`define UCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ucc: next-cycle check failed");

`endif

// ===== rtl/core/ucc_pkg.sv =====
package ucc_pkg;

  // Word layout
  localparam int TDATA_W = 72;
  localparam int YEAR_W  = 12;

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [31:0] SECS_PER_MIN  = 32'd60;
  localparam logic [31:0] SECS_YEAR     = 32'd31536000;
  localparam logic [31:0] SECS_LEAP     = 32'd31622400;
  localparam logic [31:0] SECS_DAY_NEG  = ~SECS_PER_DAY + 32'd1;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;
  localparam logic [YEAR_W-1:0] BASE_YEAR  = 12'd2000;
  localparam logic [YEAR_W-1:0] LAST_YEAR  = 12'd2099;
  localparam logic [YEAR_W-1:0] NOLEAP_CENTURY = 12'd2100;

  // Top bit of each restoring divide step
  localparam logic [2:0] DAY_TOP  = 3'd4;
  localparam logic [2:0] HOUR_TOP = 3'd4;
  localparam logic [2:0] MIN_TOP  = 3'd5;

  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_LAST  = 4'd12;
  localparam logic [3:0] MONTH_PAST  = 4'd13;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_YEAR  = 8'b0000_0010,
    S_MONTH = 8'b0000_0100,
    S_DAY   = 8'b0000_1000,
    S_HOUR  = 8'b0001_0000,
    S_MIN   = 8'b0010_0000,
    S_SEC   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // Years seen here stay within 1970..2127; 2000 is the only leap century.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'b00) && (y != NOLEAP_CENTURY);
  endfunction

  // Length of a month in seconds; months outside 1..12 read as all ones.
  function automatic logic [31:0] month_secs(input logic [3:0] m, input logic leap);
    logic [4:0] days;
    days = 5'd0;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                      days = 5'd30;
      4'd2:                                         days = leap ? 5'd29 : 5'd28;
      default:                                      days = 5'd0;
    endcase
    if (days == 5'd0) begin
      return 32'hFFFF_FFFF;
    end
    return 32'(days) * SECS_PER_DAY;
  endfunction

endpackage

// ===== rtl/core/unix_calendar_converter.sv =====
// Channel  Dir  Word
// s_*      in   tuser: op; tdata: year, month, day, hour, minute, second, unix seconds
// m_*      out  tuser: range_error; tdata: unix seconds, year, month, day, hour, min, sec
//
// One word at a time. A 33-bit add/subtract unit takes one year or month length per
// cycle, then one time-of-day term or one divide bit per cycle.
// Calendar to seconds: a step per year from 1970, per month, then day, hour, min, sec.
// Seconds to calendar: years from 1970, months, then day, hour and minute quotient bits.
// s_tready is high only while idle; the result holds on m_tdata until taken.
// rst (synchronous) returns the sequencer to idle.
module unix_calendar_converter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic                        s_tuser,  // [0] op
  // [6:0] year_since_2000, [10:7] month_in, [15:11] day_in, [20:16] hour_in,
  // [26:21] minute_in, [32:27] second_in, [64:33] unix_seconds_in, rest zero
  input  logic [ucc_pkg::TDATA_W-1:0] s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic                        m_tuser,  // [0] range_error
  // [31:0] unix_seconds_out, [38:32] year_out, [42:39] month_out, [47:43] day_out,
  // [52:48] hour_out, [58:53] minute_out, [64:59] second_out, rest zero
  output logic [ucc_pkg::TDATA_W-1:0] m_tdata
);

  ucc_pkg::state_t state, state_next;

  logic                        op;
  logic [6:0]                  ys;
  logic [3:0]                  month;
  logic [4:0]                  day;
  logic [4:0]                  hour;
  logic [5:0]                  minute;
  logic [5:0]                  second;
  logic [31:0]                 acc;
  logic [ucc_pkg::YEAR_W-1:0]  yr;
  logic [3:0]                  mo;
  logic [4:0]                  dq;
  logic [4:0]                  hq;
  logic [5:0]                  mq;
  logic [2:0]                  bitc;

  logic [ucc_pkg::YEAR_W-1:0]  yr_end;
  logic [3:0]                  mo_end;
  logic [31:0]                 term;
  logic [31:0]                 opnd;
  logic [32:0]                 sum;
  logic [31:0]                 res;
  logic                        ge;
  logic                        rng_err;

  assign yr_end = ucc_pkg::BASE_YEAR + ucc_pkg::YEAR_W'(ys);
  assign mo_end = (month > ucc_pkg::MONTH_LAST) ? ucc_pkg::MONTH_PAST : month;

  // Pick the term for this step
  always_comb begin
    case (state)
      ucc_pkg::S_YEAR:
        term = ucc_pkg::is_leap(yr) ? ucc_pkg::SECS_LEAP : ucc_pkg::SECS_YEAR;
      ucc_pkg::S_MONTH:
        term = ucc_pkg::month_secs(mo, ucc_pkg::is_leap(yr));
      ucc_pkg::S_DAY:
        term = op ? (ucc_pkg::SECS_PER_DAY << bitc) : (32'(day) * ucc_pkg::SECS_PER_DAY);
      ucc_pkg::S_HOUR:
        term = op ? (ucc_pkg::SECS_PER_HOUR << bitc) : (32'(hour) * ucc_pkg::SECS_PER_HOUR);
      ucc_pkg::S_MIN:
        term = op ? (ucc_pkg::SECS_PER_MIN << bitc) : (32'(minute) * ucc_pkg::SECS_PER_MIN);
      ucc_pkg::S_SEC:
        term = 32'(second);
      default:
        term = 32'd0;
    endcase
  end

  // Shared add/subtract: carry out is "acc >= term" when subtracting
  assign opnd = op ? ~term : term;
  assign sum  = {1'b0, acc} + {1'b0, opnd} + {32'd0, op};
  assign res  = sum[31:0];
  assign ge   = sum[32];

  // Sequence the steps
  always_comb begin
    state_next = state;
    case (state)
      ucc_pkg::S_IDLE: begin
        if (s_tvalid) state_next = ucc_pkg::S_YEAR;
      end
      ucc_pkg::S_YEAR: begin
        if (op ? !ge : (yr == yr_end)) state_next = ucc_pkg::S_MONTH;
      end
      ucc_pkg::S_MONTH: begin
        if (op ? !(ge && (mo <= ucc_pkg::MONTH_LAST)) : !(mo < mo_end)) begin
          state_next = ucc_pkg::S_DAY;
        end
      end
      ucc_pkg::S_DAY: begin
        if (!op || (bitc == 3'd0)) state_next = ucc_pkg::S_HOUR;
      end
      ucc_pkg::S_HOUR: begin
        if (!op || (bitc == 3'd0)) state_next = ucc_pkg::S_MIN;
      end
      ucc_pkg::S_MIN: begin
        if (!op) begin
          state_next = ucc_pkg::S_SEC;
        end else if (bitc == 3'd0) begin
          state_next = ucc_pkg::S_DONE;
        end
      end
      ucc_pkg::S_SEC: begin
        state_next = ucc_pkg::S_DONE;
      end
      ucc_pkg::S_DONE: begin
        if (m_tready) state_next = ucc_pkg::S_IDLE;
      end
      default: state_next = ucc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ucc_pkg::S_IDLE;
      bitc  <= 3'd0;
    end else begin
      state <= state_next;
      case (state)
        ucc_pkg::S_MONTH: bitc <= ucc_pkg::DAY_TOP;
        ucc_pkg::S_DAY:   bitc <= (bitc == 3'd0) ? ucc_pkg::HOUR_TOP : bitc - 3'd1;
        ucc_pkg::S_HOUR:  bitc <= (bitc == 3'd0) ? ucc_pkg::MIN_TOP : bitc - 3'd1;
        ucc_pkg::S_MIN:   bitc <= bitc - 3'd1;
        default:          bitc <= bitc;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ucc_pkg::S_IDLE: begin
        if (s_tvalid) begin
          op     <= s_tuser;
          ys     <= s_tdata[6:0];
          month  <= s_tdata[10:7];
          day    <= s_tdata[15:11];
          hour   <= s_tdata[20:16];
          minute <= s_tdata[26:21];
          second <= s_tdata[32:27];
          // Calendar sum starts at minus one day to cover day - 1
          acc    <= s_tuser ? s_tdata[64:33] : ucc_pkg::SECS_DAY_NEG;
          yr     <= ucc_pkg::EPOCH_YEAR;
          mo     <= ucc_pkg::MONTH_FIRST;
          dq     <= 5'd0;
          hq     <= 5'd0;
          mq     <= 6'd0;
        end
      end
      ucc_pkg::S_YEAR: begin
        if (op ? ge : (yr != yr_end)) begin
          acc <= res;
          yr  <= yr + 12'd1;
        end
      end
      ucc_pkg::S_MONTH: begin
        if (op ? (ge && (mo <= ucc_pkg::MONTH_LAST)) : (mo < mo_end)) begin
          acc <= res;
          mo  <= mo + 4'd1;
        end
      end
      ucc_pkg::S_DAY: begin
        if (!op) begin
          acc <= res;
        end else if (ge) begin
          acc      <= res;
          dq[bitc] <= 1'b1;
        end
      end
      ucc_pkg::S_HOUR: begin
        if (!op) begin
          acc <= res;
        end else if (ge) begin
          acc      <= res;
          hq[bitc] <= 1'b1;
        end
      end
      ucc_pkg::S_MIN: begin
        if (!op) begin
          acc <= res;
        end else if (ge) begin
          acc      <= res;
          mq[bitc] <= 1'b1;
        end
      end
      ucc_pkg::S_SEC: begin
        acc <= res;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // Drive the result word from held registers
  assign rng_err  = op && ((yr < ucc_pkg::BASE_YEAR) || (yr > ucc_pkg::LAST_YEAR));
  assign s_tready = (state == ucc_pkg::S_IDLE);
  assign m_tvalid = (state == ucc_pkg::S_DONE);
  assign m_tuser  = rng_err;

  always_comb begin
    m_tdata        = '0;
    m_tdata[31:0]  = op ? 32'd0 : acc;
    if (op && !rng_err) begin
      m_tdata[38:32] = 7'(yr - ucc_pkg::BASE_YEAR);
      m_tdata[42:39] = mo;
      m_tdata[47:43] = dq + 5'd1;
    end
    if (op) begin
      m_tdata[52:48] = hq;
      m_tdata[58:53] = mq;
      m_tdata[64:59] = acc[5:0];
    end
  end

endmodule

// ===== rtl/core/ucc_checker.sv =====
`include "unix_calendar_converter_defines.svh"

module ucc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic                        m_tuser,
  input logic [ucc_pkg::TDATA_W-1:0] m_tdata
);

  // No new word while a result waits
  `UCC_ASSERT_SAME(a_no_take_while_full, clk, rst, m_tvalid, !s_tready)

  // A taken word keeps the block busy and yields no result at once
  `UCC_ASSERT_NEXT(a_busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready && !m_tvalid)

  // Hold a stalled result
  `UCC_ASSERT_NEXT(a_hold_stalled, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // Return to idle once the result is taken
  `UCC_ASSERT_NEXT(a_idle_after_out, clk, rst, m_tvalid && m_tready, s_tready && !m_tvalid)

endmodule

bind unix_calendar_converter ucc_checker u_ucc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata)
);

// ===== verif/unix_calendar_converter_test.sv =====
`timescale 1ns / 1ps

module unix_calendar_converter_test;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned BASE_YEAR     = 2000;
  localparam int unsigned LAST_YEAR     = 2099;
  localparam int unsigned FEBRUARY      = 2;
  localparam int unsigned DECEMBER      = 12;
  localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  localparam bit [31:0] SECS_AT_2000 = 32'd946684800;
  localparam bit [31:0] SECS_AT_2100 = 32'd4102444800;

  localparam int unsigned MAX_WAIT    = 10;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef enum bit {
    OP_CAL_TO_UNIX = 1'b0,
    OP_UNIX_TO_CAL = 1'b1
  } conv_op_t;

  typedef struct packed {
    conv_op_t  op;
    bit [6:0]  year;
    bit [3:0]  month;
    bit [4:0]  day;
    bit [4:0]  hour;
    bit [5:0]  minute;
    bit [5:0]  second;
    bit [31:0] unix_secs;
  } conv_request_t;

  typedef struct packed {
    bit [31:0] unix_secs;
    bit [6:0]  year;
    bit [3:0]  month;
    bit [4:0]  day;
    bit [4:0]  hour;
    bit [5:0]  minute;
    bit [5:0]  second;
    bit        range_error;
  } conv_result_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic                        s_tuser = 1'b0;   // [0] op
  // [6:0] year, [10:7] month, [15:11] day, [20:16] hour, [26:21] minute,
  // [32:27] second, [64:33] unix seconds, rest zero
  logic [ucc_pkg::TDATA_W-1:0] s_tdata = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic                        m_tuser;          // [0] range_error
  // [31:0] unix seconds, [38:32] year, [42:39] month, [47:43] day,
  // [52:48] hour, [58:53] minute, [64:59] second, rest zero
  logic [ucc_pkg::TDATA_W-1:0] m_tdata;

  conv_result_t pending_results [$];
  int unsigned  fail_count = 0;
  bit           sender_gaps_on = 1'b1;
  bit           sink_stalls_on = 1'b1;
  int unsigned  hold_cycles = 0;
  int unsigned  cycle_count = 0;

  unix_calendar_converter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hold reset from the start, then release it
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  end

  // Calendar arithmetic -----------------------------------------------------

  function automatic bit gregorian_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned year_days(int unsigned y);
    return gregorian_leap(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    if (m == FEBRUARY && gregorian_leap(y)) begin
      return 29;
    end
    return MONTH_LEN[(m - 1) % 12];
  endfunction

  function automatic bit [31:0] calendar_to_seconds(conv_request_t req);
    int unsigned full_year;
    int unsigned last_month;
    int unsigned secs;
    full_year  = BASE_YEAR + req.year;
    last_month = (req.month > DECEMBER) ? DECEMBER + 1 : req.month;
    secs = 0;
    for (int unsigned y = EPOCH_YEAR; y < full_year; y++) begin
      secs += year_days(y) * SECS_PER_DAY;
    end
    for (int unsigned m = 1; m < last_month; m++) begin
      secs += month_days(m, full_year) * SECS_PER_DAY;
    end
    // day zero wraps to minus one day
    secs += (int'(req.day) - 1) * SECS_PER_DAY;
    secs += req.hour * SECS_PER_HOUR;
    secs += req.minute * SECS_PER_MIN;
    secs += req.second;
    return secs;
  endfunction

  function automatic conv_result_t seconds_to_calendar(bit [31:0] t);
    conv_result_t r;
    int unsigned  days;
    int unsigned  rem;
    int unsigned  y;
    int unsigned  mo;
    r    = '0;
    days = t / SECS_PER_DAY;
    rem  = t % SECS_PER_DAY;
    r.hour   = 5'(rem / SECS_PER_HOUR);
    r.minute = 6'((rem % SECS_PER_HOUR) / SECS_PER_MIN);
    r.second = 6'(rem % SECS_PER_MIN);
    y = EPOCH_YEAR;
    while (days >= year_days(y)) begin
      days -= year_days(y);
      y++;
    end
    mo = 1;
    while (mo <= DECEMBER && days >= month_days(mo, y)) begin
      days -= month_days(mo, y);
      mo++;
    end
    // out of century: flag it and keep only the time of day
    if (y < BASE_YEAR || y > LAST_YEAR) begin
      r.range_error = 1'b1;
    end else begin
      r.year  = 7'(y - BASE_YEAR);
      r.month = 4'(mo);
      r.day   = 5'(days + 1);
    end
    return r;
  endfunction

  function automatic conv_result_t predict_conversion(conv_request_t req);
    conv_result_t r;
    if (req.op == OP_CAL_TO_UNIX) begin
      r = '0;
      r.unix_secs = calendar_to_seconds(req);
    end else begin
      r = seconds_to_calendar(req.unix_secs);
    end
    return r;
  endfunction

  // Request builders ----------------------------------------------------------

  function automatic conv_request_t calendar_request(int unsigned y, int unsigned mo,
                                                     int unsigned d, int unsigned h,
                                                     int unsigned mi, int unsigned s);
    conv_request_t req;
    req.op        = OP_CAL_TO_UNIX;
    req.year      = 7'(y);
    req.month     = 4'(mo);
    req.day       = 5'(d);
    req.hour      = 5'(h);
    req.minute    = 6'(mi);
    req.second    = 6'(s);
    req.unix_secs = $urandom;
    return req;
  endfunction

  function automatic conv_request_t unix_request(bit [31:0] t);
    conv_request_t req;
    req           = conv_request_t'({$urandom, $urandom});
    req.op        = OP_UNIX_TO_CAL;
    req.unix_secs = t;
    return req;
  endfunction

  // Mostly in-range requests, with boundary values and full-width noise
  function automatic conv_request_t random_request();
    conv_request_t req;
    int unsigned   pick;
    int unsigned   y;
    int unsigned   mo;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      if (pick < 80) begin
        y   = $urandom_range(0, 99);
        mo  = $urandom_range(1, DECEMBER);
        req = calendar_request(y, mo, $urandom_range(1, month_days(mo, BASE_YEAR + y)),
                               $urandom_range(0, 23), $urandom_range(0, 59),
                               $urandom_range(0, 59));
      end else begin
        req    = conv_request_t'({$urandom, $urandom});
        req.op = OP_CAL_TO_UNIX;
      end
    end else begin
      if (pick < 65) begin
        req = unix_request($urandom_range(SECS_AT_2000, SECS_AT_2100 - 1));
      end else if (pick < 75) begin
        req = unix_request(SECS_AT_2000 - 32'd50000 + $urandom_range(0, 100000));
      end else if (pick < 85) begin
        req = unix_request(SECS_AT_2100 - 32'd50000 + $urandom_range(0, 100000));
      end else begin
        req = unix_request($urandom);
      end
    end
    return req;
  endfunction

  // Stream drivers ------------------------------------------------------------

  // Offer one word and record its prediction once taken; valid stays up after
  task automatic send_conversion(conv_request_t req);
    int unsigned gap;
    gap = sender_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req.op;
    s_tdata  <= {7'd0, req.unix_secs, req.second, req.minute, req.hour, req.day,
                 req.month, req.year};
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_results.push_back(predict_conversion(req));
  endtask

  // Drop valid and hold until every predicted word has come back
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, bit [31:0] expected, bit [31:0] actual);
    if (expected !== actual) begin
      $display("%0t ns: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
               $time, name, expected, expected, actual, actual);
      fail_count++;
    end
  endtask

  task automatic check_result();
    conv_result_t expected;
    if (pending_results.size() == 0) begin
      $display("%0t ns: output word with no pending conversion, tdata 0x%0h tuser %0b",
               $time, m_tdata, m_tuser);
      fail_count++;
    end else begin
      expected = pending_results.pop_front();
      check_field("unix_seconds_out", expected.unix_secs, m_tdata[31:0]);
      check_field("year_out", 32'(expected.year), 32'(m_tdata[38:32]));
      check_field("month_out", 32'(expected.month), 32'(m_tdata[42:39]));
      check_field("day_out", 32'(expected.day), 32'(m_tdata[47:43]));
      check_field("hour_out", 32'(expected.hour), 32'(m_tdata[52:48]));
      check_field("minute_out", 32'(expected.minute), 32'(m_tdata[58:53]));
      check_field("second_out", 32'(expected.second), 32'(m_tdata[64:59]));
      check_field("tdata padding", 32'd0, 32'(m_tdata[71:65]));
      check_field("range_error", 32'(expected.range_error), 32'(m_tuser));
    end
  endtask

  // Result sink: random stalls, an occasional long hold, check every word taken
  initial begin : result_sink
    int unsigned stall;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = sink_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      check_result();
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("unix_calendar_converter verification failed");
    $finish;
  end

  // Tests -----------------------------------------------------------------------

  task automatic test_calendar_cases();
    send_conversion(calendar_request(0, 1, 1, 0, 0, 0));
    send_conversion(calendar_request(99, 12, 31, 23, 59, 59));
    send_conversion(calendar_request(127, 15, 31, 31, 63, 63));
    send_conversion(calendar_request(0, 0, 0, 0, 0, 0));     // month and day zero
    send_conversion(calendar_request(4, 2, 29, 12, 30, 30));  // leap day
    send_conversion(calendar_request(100, 3, 1, 0, 0, 0));    // 2100 skips its leap day
    send_conversion(calendar_request(96, 3, 1, 0, 0, 0));
    send_conversion(calendar_request(10, 13, 5, 1, 2, 3));    // month past December
    send_conversion(calendar_request(106, 2, 7, 6, 28, 16));  // sum wraps 32 bits
    send_conversion(calendar_request(0, 1, 1, 24, 60, 60));   // time fields past range
  endtask

  task automatic test_unix_cases();
    send_conversion(unix_request(32'd0));
    send_conversion(unix_request(SECS_AT_2000 - 32'd1));
    send_conversion(unix_request(SECS_AT_2000));
    send_conversion(unix_request(32'd951782400));             // 2000-02-29
    send_conversion(unix_request(32'd951868800));             // 2000-03-01
    send_conversion(unix_request(SECS_AT_2100 - 32'd1));
    send_conversion(unix_request(SECS_AT_2100));
    send_conversion(unix_request(32'h7FFF_FFFF));
    send_conversion(unix_request(32'h8000_0000));
    send_conversion(unix_request(32'hFFFF_FFFF));
  endtask

  task automatic test_mixed_traffic(int unsigned count);
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    repeat (count) send_conversion(random_request());
  endtask

  task automatic test_streaming(int unsigned count);
    sender_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (count) send_conversion(random_request());
    wait_for_results();
  endtask

  // Hold the output for a long stretch so the block stalls its input
  task automatic test_output_backpressure(int unsigned count);
    sender_gaps_on = 1'b0;
    sink_stalls_on = 1'b1;
    hold_cycles    = HOLD_CYCLES;
    repeat (count) send_conversion(random_request());
    wait_for_results();
  endtask

  // Bursts with the sender parked until the block has drained
  task automatic test_paused_sender(int unsigned bursts, int unsigned count);
    sender_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    repeat (bursts) begin
      repeat (count) send_conversion(random_request());
      wait_for_results();
    end
  endtask

  initial begin
    while (rst !== 1'b0) @(posedge clk);
    @(posedge clk);
    test_calendar_cases();
    test_unix_cases();
    test_mixed_traffic(400);
    test_streaming(150);
    test_output_backpressure(12);
    test_paused_sender(3, 25);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("unix_calendar_converter verification clean");
    end else begin
      $display("unix_calendar_converter verification failed");
    end
    $finish;
  end

endmodule
